// ===== rtl/bmh_pkg.sv =====
// shared types and constants for the binary max-heap unit
package bmh_pkg;

  // sizing
  localparam int CAPACITY  = 64;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W    = $clog2(CAPACITY);
  localparam int COUNT_W   = $clog2(CAPACITY + 1);
  // child index of the deepest slot: two bits wider than an address, one for the doubling and one for the carry
  localparam int IDX_W     = ADDR_W + 2;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0]    addr_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [IDX_W-1:0]     idx_t;

  localparam count_t FULL_COUNT = count_t'(CAPACITY);

  // operation codes
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // command transaction
  typedef struct packed {
    op_t  func;
    key_t key_in;
  } cmd_t;

  // result transaction
  typedef struct packed {
    key_t    popped_key;
    key_t    top_key;
    count_t  entry_count;
    status_t status;
  } result_t;

endpackage

// ===== rtl/bmh_store.sv =====
// key store: one write port, two registered read ports
module bmh_store (
  input  logic          clk,
  input  logic          wr_en,
  input  bmh_pkg::addr_t wr_addr,
  input  bmh_pkg::key_t  wr_data,
  input  bmh_pkg::addr_t rd_a_addr,
  input  bmh_pkg::addr_t rd_b_addr,
  output bmh_pkg::key_t  rd_a_data,
  output bmh_pkg::key_t  rd_b_data
);
  import bmh_pkg::*;

  key_t mem [CAPACITY];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read ports, registered
  always_ff @(posedge clk) begin
    rd_a_data <= mem[rd_a_addr];
    rd_b_data <= mem[rd_b_addr];
  end

endmodule

// ===== rtl/binary_max_heap_unit.sv =====
// binary max-heap priority queue: push a key or pop the maximum, one result per command
//
// A command is taken when start is high and busy is low. Each command gives exactly one
// result, shown on result for one cycle with done high; the receiver cannot stall it.
// A push to a full heap and a pop from an empty heap answer in the cycle after the command
// and leave the heap unchanged; a pop that empties the heap answers likewise. Otherwise
// the key walks the heap one level per read-compare pass through the single key store,
// a read state and then a compare-and-write state per level, until the key stops.
// busy is high meanwhile. The key store needs no clearing after reset.
module binary_max_heap_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  bmh_pkg::cmd_t    cmd,
  output logic             busy,
  output logic             done,
  output bmh_pkg::result_t result
);
  import bmh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP_RD,
    S_UP_CMP,
    S_POP_RD,
    S_POP_LD,
    S_DN_RD,
    S_DN_CMP
  } state_t;

  state_t state;
  addr_t  pos;
  count_t count;
  key_t   key;
  key_t   top;
  key_t   popped;

  logic   wr_en;
  addr_t  wr_addr;
  key_t   wr_data;
  addr_t  rd_a_addr;
  addr_t  rd_b_addr;
  key_t   rd_a_data;
  key_t   rd_b_data;
  logic   finish;
  key_t   top_next;

  addr_t  parent;
  idx_t   child_l;
  idx_t   child_r;
  logic   l_ok;
  logic   r_ok;
  logic   pick_right;
  key_t   pick_val;
  addr_t  pick_idx;

  bmh_store u_store (
    .clk       (clk),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_a_addr (rd_a_addr),
    .rd_b_addr (rd_b_addr),
    .rd_a_data (rd_a_data),
    .rd_b_data (rd_b_data)
  );

  // heap index arithmetic around the hole
  assign parent     = addr_t'((pos - 1'b1) >> 1);
  assign child_l    = idx_t'({pos, 1'b1});
  assign child_r    = child_l + 1'b1;
  assign l_ok       = child_l < idx_t'(count);
  assign r_ok       = child_r < idx_t'(count);
  assign pick_right = r_ok && (rd_b_data > rd_a_data);
  assign pick_val   = pick_right ? rd_b_data : rd_a_data;
  assign pick_idx   = pick_right ? child_r[ADDR_W-1:0] : child_l[ADDR_W-1:0];

  // store access per state; no read whose data is used targets the slot being written, so no forwarding
  always_comb begin
    wr_en     = 1'b0;
    wr_addr   = pos;
    wr_data   = key;
    rd_a_addr = pos;
    rd_b_addr = pos;
    finish    = 1'b0;
    case (state)
      S_UP_RD: begin
        if (pos == '0) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_a_addr = parent;
        end
      end
      S_UP_CMP: begin
        wr_en = 1'b1;
        if (key > rd_a_data) begin
          wr_data = rd_a_data;
        end else begin
          finish = 1'b1;
        end
      end
      S_POP_RD: begin
        rd_a_addr = count[ADDR_W-1:0];
      end
      S_DN_RD: begin
        if (!l_ok) begin
          wr_en  = 1'b1;
          finish = 1'b1;
        end else begin
          rd_a_addr = child_l[ADDR_W-1:0];
          rd_b_addr = child_r[ADDR_W-1:0];
        end
      end
      S_DN_CMP: begin
        wr_en = 1'b1;
        if (pick_val > key) begin
          wr_data = pick_val;
        end else begin
          finish = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // shadow of the root slot
  assign top_next = (wr_en && (wr_addr == '0)) ? wr_data : top;

  // sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      top  <= top_next;
      case (state)
        S_IDLE: begin
          if (start) begin
            if (cmd.func == OP_PUSH) begin
              if (count == FULL_COUNT) begin
                done   <= 1'b1;
                result <= '{popped_key: '0, top_key: top, entry_count: count,
                            status: ST_FULL};
              end else begin
                key    <= cmd.key_in;
                pos    <= count[ADDR_W-1:0];
                count  <= count + 1'b1;
                popped <= '0;
                busy   <= 1'b1;
                state  <= S_UP_RD;
              end
            end else begin
              if (count == '0) begin
                done   <= 1'b1;
                result <= '{popped_key: '0, top_key: '0, entry_count: '0,
                            status: ST_EMPTY};
              end else if (count == count_t'(1)) begin
                count  <= '0;
                done   <= 1'b1;
                result <= '{popped_key: top, top_key: '0, entry_count: '0,
                            status: ST_OK};
              end else begin
                popped <= top;
                count  <= count - 1'b1;
                busy   <= 1'b1;
                state  <= S_POP_RD;
              end
            end
          end
        end
        S_UP_RD: begin
          state <= S_UP_CMP;
        end
        S_UP_CMP: begin
          pos   <= parent;
          state <= S_UP_RD;
        end
        S_POP_RD: begin
          state <= S_POP_LD;
        end
        S_POP_LD: begin
          key   <= rd_a_data;
          pos   <= '0;
          state <= S_DN_RD;
        end
        S_DN_RD: begin
          state <= S_DN_CMP;
        end
        S_DN_CMP: begin
          pos   <= pick_idx;
          state <= S_DN_RD;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // end of a sift: the transaction completes
      if (finish) begin
        state  <= S_IDLE;
        busy   <= 1'b0;
        done   <= 1'b1;
        result <= '{popped_key: popped, top_key: top_next, entry_count: count,
                    status: ST_OK};
      end
    end
  end

  // checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while still busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("entry count beyond capacity");

  a_busy_state: assert property (@(posedge clk) disable iff (rst)
    busy |-> (state != S_IDLE))
    else $error("busy while sequencer idle");

  a_full_push: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.func == OP_PUSH) && (count == FULL_COUNT))
      |=> (done && (result.status == ST_FULL)))
    else $error("push on full heap not flagged");

  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.func == OP_POP) && (count == '0))
      |=> (done && (result.status == ST_EMPTY) && (result.entry_count == '0)))
    else $error("pop on empty heap not flagged");

endmodule
